// ===== rtl/esv_pkg.sv =====
// Package for the ElGamal sign/verify engine: widths, register indexes, opcodes.
// Used by every module of the block.
package esv_pkg;
    localparam int DefWidth = 32;
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] RegPrime = 2'd0;
    localparam logic [CfgIdxW-1:0] RegGen = 2'd1;
    localparam logic [CfgIdxW-1:0] RegPriv = 2'd2;
    localparam logic [CfgIdxW-1:0] RegPub = 2'd3;
    localparam logic OpSign = 1'b0;
    localparam logic OpVerify = 1'b1;
endpackage

// ===== rtl/esv_modmul.sv =====
// Bit-serial modular multiplier: one bit of b per cycle, double and add.
// Depends on esv_pkg.
module esv_modmul #(
    parameter int WIDTH = esv_pkg::DefWidth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] prod
);
    import esv_pkg::*;
    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [1:0] {IDLE, RED_A, RED_B, RUN} st_t;
    st_t st_reg;
    logic [WIDTH-1:0] a_reg, b_reg, acc_reg;
    logic [CW-1:0] cnt_reg;
    logic done_reg;

    // Reductions of operands below m by repeated subtraction would be slow for wide
    // values, so operand a is reduced bit-serially as a*1 via the same loop.
    logic [WIDTH:0] dbl, dsum;
    logic [WIDTH-1:0] dbl_m, addv;
    always_comb begin
        dbl = {acc_reg, 1'b0};
        dbl_m = (dbl >= {1'b0, m}) ? WIDTH'(dbl - {1'b0, m}) : dbl[WIDTH-1:0];
        addv = b_reg[WIDTH-1] ? a_reg : '0;
        dsum = {1'b0, dbl_m} + {1'b0, addv};
        if (dsum >= {1'b0, m}) dsum = dsum - {1'b0, m};
    end

    // RED_A: reduce a mod m by computing a*1 with a as the serial operand.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (st_reg)
                IDLE: if (start) begin
                    a_reg <= WIDTH'(1) % 1 == 0 ? WIDTH'(1) : '0;
                    b_reg <= a;
                    acc_reg <= '0;
                    cnt_reg <= CW'(WIDTH);
                    st_reg <= RED_A;
                end
                RED_A: begin
                    acc_reg <= WIDTH'(dsum);
                    b_reg <= b_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        a_reg <= WIDTH'(dsum);
                        b_reg <= b;
                        acc_reg <= '0;
                        cnt_reg <= CW'(WIDTH);
                        st_reg <= RUN;
                    end
                end
                RUN: begin
                    acc_reg <= WIDTH'(dsum);
                    b_reg <= b_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        done_reg <= 1'b1;
                        st_reg <= IDLE;
                    end
                end
                default: st_reg <= IDLE;
            endcase
        end
    end
    // m below 2: result zero; 1 % 1 handled since acc reduces below m only for m>=1.
    assign done = done_reg;
    assign prod = (m == '0) ? '0 : (m == WIDTH'(1)) ? '0 : acc_reg;
endmodule

// ===== rtl/esv_core.sv =====
// Sequencer for sign and verify: exponentiations, inverse by extended Euclid with a
// bit-serial divider. Depends on esv_pkg and esv_modmul.
module esv_core #(
    parameter int WIDTH = esv_pkg::DefWidth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             op,
    input  logic [WIDTH-1:0] msg,
    input  logic [WIDTH-1:0] k,
    input  logic [WIDTH-1:0] sr,
    input  logic [WIDTH-1:0] ss,
    input  logic [WIDTH-1:0] p,
    input  logic [WIDTH-1:0] g,
    input  logic [WIDTH-1:0] d,
    input  logic [WIDTH-1:0] beta,
    output logic             busy,
    output logic             fin,
    output logic [31:0]      r_out,
    output logic [31:0]      s_out,
    output logic             valid_out,
    output logic             kerr_out
);
    import esv_pkg::*;
    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [4:0] {
        IDLE, INV_INIT, INV_RED, INV_LOOP, INV_DIV, INV_STEP, INV_FIX, PW_INIT, PW_MUL,
        PW_MW, PW_SQ, PW_SW, PW_NEXT, AFTER_PW, DR_W, DIFF, S_W, V_W, FINISH
    } st_t;
    st_t st_reg;

    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] e0_reg, e1_reg, et0_reg, et1_reg, dvd_reg, rem_reg, qacc_reg;
    logic [WIDTH-1:0] kinv_reg;
    logic [WIDTH-1:0] base_reg, exp_reg, pacc_reg, m_reg;
    logic [CW-1:0] bit_reg;
    logic [1:0] phase_reg;
    logic [WIDTH-1:0] r_reg, t0_reg, t1_reg, s_reg;
    logic valid_reg, kerr_reg, fin_reg;
    logic op_reg;
    logic [WIDTH-1:0] msg_reg, k_reg, sr_reg, ss_reg;
    logic [WIDTH-1:0] ma_reg, mb_reg;
    logic mstart_reg, mdone;
    logic [WIDTH-1:0] mprod;

    esv_modmul #(.WIDTH(WIDTH)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mstart_reg), .a(ma_reg), .b(mb_reg),
        .m(m_reg), .done(mdone), .prod(mprod)
    );

    // One quotient bit per cycle; the quotient times t1 is folded in mod n as it goes.
    logic [WIDTH:0] rsh, rnext, qdbl, qsum;
    logic [WIDTH-1:0] qdbl_m, qadd;
    logic qbit;
    always_comb begin
        rsh = {rem_reg, dvd_reg[WIDTH-1]};
        qbit = (rsh >= {1'b0, e1_reg});
        rnext = qbit ? rsh - {1'b0, e1_reg} : rsh;
        qdbl = {qacc_reg, 1'b0};
        qdbl_m = (qdbl >= {1'b0, n_reg}) ? WIDTH'(qdbl - {1'b0, n_reg}) : qdbl[WIDTH-1:0];
        qadd = qbit ? et1_reg : '0;
        qsum = {1'b0, qdbl_m} + {1'b0, qadd};
        if (qsum >= {1'b0, n_reg}) qsum = qsum - {1'b0, n_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= IDLE;
            mstart_reg <= 1'b0;
            fin_reg <= 1'b0;
        end else begin
            mstart_reg <= 1'b0;
            fin_reg <= 1'b0;
            unique case (st_reg)
                IDLE: if (start) begin
                    r_reg <= '0; s_reg <= '0; valid_reg <= 1'b0; kerr_reg <= 1'b0;
                    op_reg <= op; msg_reg <= msg; k_reg <= k; sr_reg <= sr; ss_reg <= ss;
                    n_reg <= p - 1'b1;
                    m_reg <= p;
                    if (p < WIDTH'(2)) begin
                        kerr_reg <= (op == OpSign);
                        st_reg <= FINISH;
                    end else if (op == OpSign) begin
                        st_reg <= INV_INIT;
                    end else begin
                        base_reg <= g; exp_reg <= msg; phase_reg <= 2'd0;
                        st_reg <= PW_INIT;
                    end
                end
                INV_INIT: begin
                    // With n equal to one every key is invertible and the inverse is zero.
                    if (n_reg == WIDTH'(1)) begin
                        kinv_reg <= '0;
                        base_reg <= g; exp_reg <= k_reg; phase_reg <= 2'd0;
                        st_reg <= PW_INIT;
                    end else begin
                        m_reg <= n_reg;
                        ma_reg <= k_reg; mb_reg <= WIDTH'(1); mstart_reg <= 1'b1;
                        st_reg <= INV_RED;
                    end
                end
                INV_RED: if (mdone) begin
                    e0_reg <= n_reg; e1_reg <= mprod;
                    et0_reg <= '0; et1_reg <= WIDTH'(1);
                    st_reg <= INV_LOOP;
                end
                INV_LOOP: begin
                    if (e1_reg == '0) begin
                        st_reg <= INV_FIX;
                    end else begin
                        dvd_reg <= e0_reg; rem_reg <= '0; qacc_reg <= '0;
                        bit_reg <= CW'(WIDTH);
                        st_reg <= INV_DIV;
                    end
                end
                INV_DIV: begin
                    rem_reg <= WIDTH'(rnext);
                    dvd_reg <= dvd_reg << 1;
                    qacc_reg <= WIDTH'(qsum);
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == CW'(1)) st_reg <= INV_STEP;
                end
                INV_STEP: begin
                    e0_reg <= e1_reg; e1_reg <= rem_reg;
                    et0_reg <= et1_reg;
                    et1_reg <= (et0_reg >= qacc_reg) ? et0_reg - qacc_reg
                                                     : et0_reg + (n_reg - qacc_reg);
                    st_reg <= INV_LOOP;
                end
                INV_FIX: begin
                    if (e0_reg != WIDTH'(1)) begin
                        kerr_reg <= 1'b1;
                        st_reg <= FINISH;
                    end else begin
                        kinv_reg <= et0_reg;
                        base_reg <= g; exp_reg <= k_reg; phase_reg <= 2'd0;
                        st_reg <= PW_INIT;
                    end
                end
                PW_INIT: begin
                    pacc_reg <= WIDTH'(1);
                    bit_reg <= CW'(WIDTH);
                    m_reg <= p;
                    st_reg <= PW_MUL;
                end
                PW_MUL: begin
                    if (exp_reg[0]) begin
                        ma_reg <= pacc_reg; mb_reg <= base_reg; mstart_reg <= 1'b1;
                        st_reg <= PW_MW;
                    end else st_reg <= PW_SQ;
                end
                PW_MW: if (mdone) begin
                    pacc_reg <= mprod; st_reg <= PW_SQ;
                end
                PW_SQ: begin
                    ma_reg <= base_reg; mb_reg <= base_reg; mstart_reg <= 1'b1;
                    st_reg <= PW_SW;
                end
                PW_SW: if (mdone) begin
                    base_reg <= mprod; st_reg <= PW_NEXT;
                end
                PW_NEXT: begin
                    exp_reg <= exp_reg >> 1;
                    bit_reg <= bit_reg - 1'b1;
                    st_reg <= (bit_reg == CW'(1)) ? AFTER_PW : PW_MUL;
                end
                AFTER_PW: begin
                    if (op_reg == OpSign) begin
                        r_reg <= pacc_reg;
                        m_reg <= n_reg;
                        ma_reg <= d; mb_reg <= pacc_reg; mstart_reg <= 1'b1;
                        st_reg <= DR_W;
                    end else if (phase_reg == 2'd0) begin
                        t0_reg <= pacc_reg;
                        base_reg <= beta; exp_reg <= sr_reg; phase_reg <= 2'd1;
                        st_reg <= PW_INIT;
                    end else if (phase_reg == 2'd1) begin
                        t1_reg <= pacc_reg;
                        base_reg <= sr_reg; exp_reg <= ss_reg; phase_reg <= 2'd2;
                        st_reg <= PW_INIT;
                    end else begin
                        ma_reg <= t1_reg; mb_reg <= pacc_reg; mstart_reg <= 1'b1;
                        st_reg <= V_W;
                    end
                end
                DR_W: if (mdone) begin
                    t1_reg <= mprod;
                    ma_reg <= msg_reg; mb_reg <= WIDTH'(1); mstart_reg <= 1'b1;
                    st_reg <= DIFF;
                end
                DIFF: if (mdone) begin
                    ma_reg <= (mprod >= t1_reg) ? mprod - t1_reg : mprod + (n_reg - t1_reg);
                    mb_reg <= kinv_reg; mstart_reg <= 1'b1;
                    st_reg <= S_W;
                end
                S_W: if (mdone) begin
                    s_reg <= mprod; st_reg <= FINISH;
                end
                V_W: if (mdone) begin
                    valid_reg <= (mprod == t0_reg); st_reg <= FINISH;
                end
                FINISH: begin
                    fin_reg <= 1'b1; st_reg <= IDLE;
                end
                default: st_reg <= IDLE;
            endcase
        end
    end

    assign busy = (st_reg != IDLE) || fin_reg;
    assign fin = fin_reg;
    assign r_out = 32'(r_reg);
    assign s_out = 32'(s_reg);
    assign valid_out = valid_reg;
    assign kerr_out = kerr_reg;

    a_fin_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> $past(st_reg) == FINISH) else $error("fin without finish");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> !(valid_reg && kerr_reg)) else $error("valid and key error");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_reg && kerr_reg) |-> (r_reg == '0 && s_reg == '0)) else $error("err nonzero");
endmodule

// ===== rtl/elgamal_sign_verify.sv =====
// ElGamal sign/verify engine over a configured prime modulus: top level with
// configuration registers and output register. Depends on esv_pkg and esv_core.
// One request is processed at a time. Everything runs through a single bit-serial
// modular multiplier; a sign request costs an extended-Euclid inverse (one
// product to reduce k, then up to about 1.5*WIDTH bit-serial division steps) plus
// WIDTH to 2*WIDTH products for g^k, and three more; a verify request costs three
// exponentiations, up to 6*WIDTH+1 products.
module elgamal_sign_verify #(
    parameter int WIDTH = esv_pkg::DefWidth
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [esv_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [WIDTH-1:0]            cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [31:0]                 s_message,
    input  logic [31:0]                 s_ephemeral_key,
    input  logic [31:0]                 s_sig_r,
    input  logic [31:0]                 s_sig_s,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [31:0]                 m_out_r,
    output logic [31:0]                 m_out_s,
    output logic                        m_valid_res,
    output logic                        m_key_error
);
    import esv_pkg::*;

    logic [WIDTH-1:0] p_reg, g_reg, d_reg, b_reg;
    logic busy, fin, valid_o, kerr_o, mv_reg;
    logic [31:0] r_o, s_o;
    logic [WIDTH-1:0] msg_x, k_x, sr_x, ss_x;

    function automatic logic [WIDTH-1:0] fit(input logic [31:0] x);
        logic [63:0] t;
        t = {32'd0, x};
        return t[WIDTH-1:0];
    endfunction

    assign msg_x = fit(s_message);
    assign k_x = fit(s_ephemeral_key);
    assign sr_x = fit(s_sig_r);
    assign ss_x = fit(s_sig_s);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= WIDTH'(877); g_reg <= WIDTH'(6);
            d_reg <= WIDTH'(59); b_reg <= WIDTH'(349);
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegPrime: p_reg <= cfg_data;
                RegGen: g_reg <= cfg_data;
                RegPriv: d_reg <= cfg_data;
                RegPub: b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !busy && !mv_reg;

    esv_core #(.WIDTH(WIDTH)) u_core (
        .aclk(aclk), .aresetn(aresetn), .start(s_valid && s_ready), .op(s_operation),
        .msg(msg_x), .k(k_x), .sr(sr_x), .ss(ss_x), .p(p_reg), .g(g_reg), .d(d_reg),
        .beta(b_reg), .busy(busy), .fin(fin), .r_out(r_o), .s_out(s_o),
        .valid_out(valid_o), .kerr_out(kerr_o)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else begin
            if (fin) begin
                mv_reg <= 1'b1;
                m_out_r <= r_o; m_out_s <= s_o;
                m_valid_res <= valid_o; m_key_error <= kerr_o;
            end else if (m_ready) mv_reg <= 1'b0;
        end
    end
    assign m_valid = mv_reg;
endmodule

// ===== bench/tb_elgamal_sign_verify.sv =====
// Self-checking testbench for elgamal_sign_verify: signs and verifies requests under
// several key and modulus settings, predicting each result in a small ledger class.
// Depends on esv_pkg and the elgamal_sign_verify RTL.
`timescale 1ns / 100ps

module tb_elgamal_sign_verify;
    import esv_pkg::*;

    localparam int StallLimit = 400000;

    typedef struct packed {
        logic        operation;
        logic [31:0] message;
        logic [31:0] ephemeral_key;
        logic [31:0] sig_r;
        logic [31:0] sig_s;
    } sig_request_t;

    typedef struct packed {
        logic [31:0] out_r;
        logic [31:0] out_s;
        logic        valid_res;
        logic        key_error;
    } sig_outcome_t;

    class signature_ledger;
        logic [31:0]  modulus, gen, priv, pub;
        sig_outcome_t awaited[$];
        int           failures;

        function new();
            modulus = 32'd877;
            gen = 32'd6;
            priv = 32'd59;
            pub = 32'd349;
            failures = 0;
        endfunction

        function logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
            return ((a % m) * (b % m)) % m;
        endfunction

        function logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
            logic [63:0] acc;
            acc = 64'd1 % m;
            base = base % m;
            while (e != 0) begin
                if (e[0]) acc = mulmod(acc, base, m);
                base = mulmod(base, base, m);
                e = e >> 1;
            end
            return acc;
        endfunction

        function bit invmod(logic [63:0] a, logic [63:0] n, output logic [63:0] inv);
            logic [63:0] r0, r1, t0, t1, q, nr, nt, prod;
            r0 = n;
            r1 = a % n;
            t0 = 0;
            t1 = 64'd1 % n;
            inv = 0;
            while (r1 != 0) begin
                q = r0 / r1;
                nr = r0 - q * r1;
                prod = mulmod(q, t1, n);
                nt = (t0 >= prod) ? t0 - prod : t0 + (n - prod);
                r0 = r1;
                r1 = nr;
                t0 = t1;
                t1 = nt;
            end
            inv = t0;
            return r0 == 1;
        endfunction

        function sig_outcome_t compute(sig_request_t req);
            sig_outcome_t res;
            logic [63:0] p, n, kinv, r, dr, mr, diff, lhs, rhs;
            res = '0;
            p = modulus;
            if (req.operation == OpSign) begin
                if (p < 2) begin
                    res.key_error = 1'b1;
                end else begin
                    n = p - 1;
                    if (!invmod(req.ephemeral_key, n, kinv)) begin
                        res.key_error = 1'b1;
                    end else begin
                        r = powmod(gen, req.ephemeral_key, p);
                        dr = mulmod(priv, r, n);
                        mr = req.message % n;
                        diff = (mr >= dr) ? mr - dr : mr + (n - dr);
                        res.out_r = r[31:0];
                        res.out_s = 32'(mulmod(diff, kinv, n));
                    end
                end
            end else if (p >= 2) begin
                lhs = powmod(gen, req.message, p);
                rhs = mulmod(powmod(pub, req.sig_r, p), powmod(req.sig_r, req.sig_s, p), p);
                res.valid_res = (lhs == rhs);
            end
            return res;
        endfunction

        function void note_request(sig_request_t req);
            awaited.push_back(compute(req));
        endfunction

        function void check_result(sig_outcome_t got);
            sig_outcome_t exp;
            if (awaited.size() == 0) begin
                $error("unexpected result r=%0h s=%0h", got.out_r, got.out_s);
                failures++;
                return;
            end
            exp = awaited.pop_front();
            if (got.out_r !== exp.out_r) begin
                $error("out_r: expected %0h, got %0h", exp.out_r, got.out_r);
                failures++;
            end
            if (got.out_s !== exp.out_s) begin
                $error("out_s: expected %0h, got %0h", exp.out_s, got.out_s);
                failures++;
            end
            if (got.valid_res !== exp.valid_res) begin
                $error("valid_res: expected %0b, got %0b", exp.valid_res, got.valid_res);
                failures++;
            end
            if (got.key_error !== exp.key_error) begin
                $error("key_error: expected %0b, got %0b", exp.key_error, got.key_error);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [31:0] s_message, s_ephemeral_key, s_sig_r, s_sig_s;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_r, m_out_s;
    logic        m_valid_res, m_key_error;

    signature_ledger ledger;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    elgamal_sign_verify u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_message      (s_message),
        .s_ephemeral_key(s_ephemeral_key),
        .s_sig_r        (s_sig_r),
        .s_sig_s        (s_sig_s),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_r        (m_out_r),
        .m_out_s        (m_out_s),
        .m_valid_res    (m_valid_res),
        .m_key_error    (m_key_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                ledger.check_result({m_out_r, m_out_s, m_valid_res, m_key_error});
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("elgamal_sign_verify: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            RegPrime: ledger.modulus = value;
            RegGen:   ledger.gen = value;
            RegPriv:  ledger.priv = value;
            default:  ledger.pub = value;
        endcase
    endtask

    task automatic set_keys(logic [31:0] p, logic [31:0] g, logic [31:0] d, logic [31:0] b);
        write_reg(RegPrime, p);
        write_reg(RegGen, g);
        write_reg(RegPriv, d);
        write_reg(RegPub, b);
    endtask

    task automatic send_request(sig_request_t req);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid <= 1'b1;
        s_operation <= req.operation;
        s_message <= req.message;
        s_ephemeral_key <= req.ephemeral_key;
        s_sig_r <= req.sig_r;
        s_sig_s <= req.sig_s;
        do @(posedge aclk); while (!s_ready);
        ledger.note_request(req);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic sign_then_check(logic [31:0] msg, logic [31:0] k, bit corrupt);
        sig_request_t req;
        sig_outcome_t sig;
        req = '{OpSign, msg, k, $urandom, $urandom};
        send_request(req);
        sig = ledger.compute(req);
        req = '{OpVerify, msg, $urandom, sig.out_r, sig.out_s};
        if (corrupt) req.sig_s = req.sig_s ^ (32'd1 << $urandom_range(31));
        send_request(req);
    endtask

    task automatic random_requests(int count);
        sig_request_t req;
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                sign_then_check($urandom, $urandom, kind == 0);
            end else begin
                req = '{1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom};
                if (kind == 9) req.sig_r = $urandom_range(ledger.modulus);
                send_request(req);
            end
        end
    endtask

    task automatic drain();
        while (ledger.awaited.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        ledger = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_operation = OpSign;
        s_message = '0;
        s_ephemeral_key = '0;
        s_sig_r = '0;
        s_sig_s = '0;
        send_idle_pct = 6;
        recv_stall_pct = 83;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request('{OpSign, 32'd0, 32'd1, 32'd0, 32'd0});
        send_request('{OpSign, 32'hffffffff, 32'd5, 32'd0, 32'd0});
        send_request('{OpSign, 32'd100, 32'd0, 32'd0, 32'd0});
        send_request('{OpSign, 32'd100, 32'd2, 32'd0, 32'd0});
        send_request('{OpSign, 32'd100, 32'd876, 32'd0, 32'd0});
        send_request('{OpSign, 32'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        send_request('{OpVerify, 32'd0, 32'd0, 32'd0, 32'd0});
        send_request('{OpVerify, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        send_request('{OpVerify, 32'd5, 32'd0, 32'd877, 32'd3});
        sign_then_check(32'd500, 32'd7, 1'b0);
        sign_then_check(32'hffffffff, 32'd877, 1'b0);
        sign_then_check(32'd12, 32'd11, 1'b1);
        drain();

        set_keys(32'd4294967291, 32'd2, 32'h2468ace1, 32'd0);
        write_reg(RegPub, ledger.powmod(32'd2, 32'h2468ace1, 32'd4294967291));
        random_requests(15);
        drain();

        set_keys(32'd3, 32'd2, 32'd0, 32'd1);
        random_requests(8);
        drain();

        send_idle_pct = 83;
        recv_stall_pct = 6;
        set_keys(32'd877, 32'hffffffff, 32'hffffffff, 32'd0);
        write_reg(RegPub, ledger.powmod(32'hffffffff, 32'hffffffff, 32'd877));
        random_requests(10);
        drain();

        set_keys(32'd65521, 32'd17, $urandom, $urandom);
        random_requests(8);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_keys(32'd2, 32'd1, 32'd1, 32'hffffffff);
        random_requests(5);
        drain();

        set_keys(32'd0, 32'd0, 32'd3, 32'd0);
        random_requests(3);
        drain();

        write_reg(RegPrime, 32'd1);
        random_requests(3);
        drain();

        repeat (50) @(posedge aclk);
        if (ledger.failures == 0 && ledger.awaited.size() == 0) begin
            $display("elgamal_sign_verify: match");
        end else begin
            $display("elgamal_sign_verify: mismatch");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/esv_pkg.sv
rtl/esv_modmul.sv
rtl/esv_core.sv
rtl/elgamal_sign_verify.sv
bench/tb_elgamal_sign_verify.sv
